// ===== hw/rtl/mtt_pkg.sv =====
// Package for the multi timer table: operation, result and slot-state codes,
// and the payload types of the input and output channels. No dependencies.
package mtt_pkg;

  localparam logic [2:0] OP_ALLOC = 3'd0;
  localparam logic [2:0] OP_FREE  = 3'd1;
  localparam logic [2:0] OP_BIND  = 3'd2;
  localparam logic [2:0] OP_ARM   = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FULL    = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_ARMED = 2'd2;

  localparam logic [31:0] NO_DEADLINE = 32'hFFFF_FFFF;

  // At most this many expirations are reported by one tick.
  localparam int RESULT_LIMIT = 16;
  localparam int RES_CNT_W    = $clog2(RESULT_LIMIT + 1);

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  timer_index;
    logic [31:0] delay_ticks;
    logic [7:0]  tag;
    logic [2:0]  dest_queue;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot;
    logic [7:0] tag_out;
    logic [2:0] queue_out;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] due;
    logic [7:0]  tag;
    logic [2:0]  queue;
  } slot_rec_t;

endpackage

// ===== hw/rtl/mtt_intf.sv =====
// Valid/ready channel interfaces of the multi timer table.
// Depends on mtt_pkg for the payload types.
interface mtt_in_if;
  logic               valid;
  logic               ready;
  mtt_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mtt_out_if;
  logic               valid;
  logic               ready;
  mtt_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mtt_slot_ram.sv =====
// Per-slot record memory: deadline, tag and destination queue, one write
// port with separate field enables and one registered read port. Uses mtt_pkg.
module mtt_slot_ram #(
  parameter int  NUM_SLOTS = 16,
  localparam int IdxW      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                clk_i,
  input  logic [IdxW-1:0]     wr_idx_i,
  input  logic                due_we_i,
  input  logic [31:0]         due_i,
  input  logic                bind_we_i,
  input  logic [7:0]          tag_i,
  input  logic [2:0]          queue_i,
  input  logic                rd_en_i,
  input  logic [IdxW-1:0]     rd_idx_i,
  output mtt_pkg::slot_rec_t  rd_o
);

  logic [31:0] due_mem   [NUM_SLOTS];
  logic [7:0]  tag_mem   [NUM_SLOTS];
  logic [2:0]  queue_mem [NUM_SLOTS];
  mtt_pkg::slot_rec_t rd_q;

  always_ff @(posedge clk_i) begin
    if (due_we_i) begin
      due_mem[wr_idx_i] <= due_i;
    end
    if (bind_we_i) begin
      tag_mem[wr_idx_i]   <= tag_i;
      queue_mem[wr_idx_i] <= queue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q.due   <= due_mem[rd_idx_i];
      rd_q.tag   <= tag_mem[rd_idx_i];
      rd_q.queue <= queue_mem[rd_idx_i];
    end
  end

  assign rd_o = rd_q;

endmodule

// ===== hw/rtl/multi_timer_table.sv =====
// Multi timer table: a table of timer slots with a tick counter and an
// earliest-deadline register. Uses mtt_pkg, mtt_intf and mtt_slot_ram.
//
// Usage: operations arrive on in_i (allocate, free, bind, arm, tick) and
// results leave on out_o (slot allocated, no free slot, slot expired), each
// a valid/ready transaction. in_i is ready only while the sequencer is idle.
// Free, bind and arm give no result and leave the sequencer idle, as does a
// tick that does not reach the earliest deadline. Allocate searches the slot
// states one slot per cycle, waits for the output register at the first free
// slot or after the last one, and gives exactly one result. A tick that
// reaches the deadline scans the slots in index order: a slot that is not
// armed is skipped, an armed slot is read and then checked (the record
// memory read is registered), and a final step sends the last held result.
// Each expired slot gives one result; the last one carries last=1.
// Results pass through an output register, so a finished result may wait
// while the block starts the next operation. When out_o stalls, the
// sequencer waits in place until the output register frees up.
// Reset frees every slot, clears the tick count and sets the earliest
// deadline to all ones; the slot records are not cleared.
module multi_timer_table #(
  parameter int NUM_SLOTS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  mtt_in_if.sink          in_i,
  mtt_out_if.source       out_o
);

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ResW = mtt_pkg::RES_CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EV    = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]          fsm_q, fsm_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [31:0]         tick_q, tick_d;
  logic [31:0]         next_due_q, next_due_d;
  logic [1:0]          slot_st_q [NUM_SLOTS];
  logic [1:0]          slot_st_d [NUM_SLOTS];
  logic [ResW-1:0]     res_cnt_q, res_cnt_d;
  logic                pend_v_q, pend_v_d;
  mtt_pkg::out_item_t  pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  mtt_pkg::out_item_t  out_q, out_d;
  logic                out_load;

  mtt_pkg::in_item_t   item;
  mtt_pkg::slot_rec_t  rd;
  logic                in_fire;
  logic                out_free;
  logic                idx_ok;
  logic [IdxW-1:0]     tidx;
  logic [31:0]         arm_due;
  logic [31:0]         tick_inc;
  logic                is_last;
  logic [1:0]          cur_st;
  logic                expired;
  logic                due_we;
  logic                bind_we;
  logic                rd_en;

  assign item     = in_i.data;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign idx_ok   = 32'(item.timer_index) < 32'(NUM_SLOTS);
  assign tidx     = IdxW'(item.timer_index);
  assign arm_due  = tick_q + item.delay_ticks;
  assign tick_inc = tick_q + 32'd1;
  assign is_last  = idx_q == IdxW'(NUM_SLOTS - 1);
  assign cur_st   = slot_st_q[idx_q];
  assign expired  = (rd.due <= tick_q) && (res_cnt_q < ResW'(mtt_pkg::RESULT_LIMIT));

  mtt_slot_ram #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_idx_i  (tidx),
    .due_we_i  (due_we),
    .due_i     (arm_due),
    .bind_we_i (bind_we),
    .tag_i     (item.tag),
    .queue_i   (item.dest_queue),
    .rd_en_i   (rd_en),
    .rd_idx_i  (idx_q),
    .rd_o      (rd)
  );

  always_comb begin
    logic adv;
    adv         = 1'b0;
    fsm_d       = fsm_q;
    idx_d       = idx_q;
    tick_d      = tick_q;
    next_due_d  = next_due_q;
    slot_st_d   = slot_st_q;
    res_cnt_d   = res_cnt_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    out_load    = 1'b0;
    out_d       = out_q;
    due_we      = 1'b0;
    bind_we     = 1'b0;
    rd_en       = 1'b0;

    unique case (fsm_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (item.op)
            mtt_pkg::OP_ALLOC: begin
              idx_d = '0;
              fsm_d = S_ALLOC;
            end
            mtt_pkg::OP_FREE: begin
              if (idx_ok) begin
                slot_st_d[tidx] = mtt_pkg::ST_FREE;
              end
            end
            mtt_pkg::OP_BIND: begin
              bind_we = idx_ok;
            end
            mtt_pkg::OP_ARM: begin
              if (idx_ok) begin
                due_we          = 1'b1;
                slot_st_d[tidx] = mtt_pkg::ST_ARMED;
                if (next_due_q > arm_due) begin
                  next_due_d = arm_due;
                end
              end
            end
            mtt_pkg::OP_TICK: begin
              tick_d = tick_inc;
              if (!(next_due_q > tick_inc)) begin
                next_due_d = mtt_pkg::NO_DEADLINE;
                idx_d      = '0;
                res_cnt_d  = '0;
                fsm_d      = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ALLOC: begin
        if (cur_st == mtt_pkg::ST_FREE) begin
          if (out_free) begin
            slot_st_d[idx_q] = mtt_pkg::ST_ALLOC;
            out_load = 1'b1;
            out_d    = '{kind: mtt_pkg::KIND_ALLOC, slot: 4'(idx_q), tag_out: 8'd0,
                         queue_out: 3'd0, last: 1'b1};
            fsm_d    = S_IDLE;
          end
        end else if (is_last) begin
          if (out_free) begin
            out_load = 1'b1;
            out_d    = '{kind: mtt_pkg::KIND_FULL, slot: 4'd0, tag_out: 8'd0,
                         queue_out: 3'd0, last: 1'b1};
            fsm_d    = S_IDLE;
          end
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_RD: begin
        if (cur_st == mtt_pkg::ST_ARMED) begin
          rd_en = 1'b1;
          fsm_d = S_EV;
        end else begin
          adv = 1'b1;
        end
      end
      S_EV: begin
        if (expired) begin
          // The held result goes out only once a later one proves it is not last.
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_load = 1'b1;
              out_d    = pend_q;
            end
            pend_v_d         = 1'b1;
            pend_d           = '{kind: mtt_pkg::KIND_EXPIRED, slot: 4'(idx_q),
                                 tag_out: rd.tag, queue_out: rd.queue, last: 1'b0};
            slot_st_d[idx_q] = mtt_pkg::ST_ALLOC;
            res_cnt_d        = res_cnt_q + ResW'(1);
            adv              = 1'b1;
          end
        end else begin
          if (next_due_q > rd.due) begin
            next_due_d = rd.due;
          end
          adv = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!pend_v_q) begin
          fsm_d = S_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_d      = pend_q;
          out_d.last = 1'b1;
          pend_v_d   = 1'b0;
          fsm_d      = S_IDLE;
        end
      end
      default: begin
        fsm_d = S_IDLE;
      end
    endcase

    if (adv) begin
      if (is_last) begin
        fsm_d = S_FLUSH;
      end else begin
        idx_d = idx_q + IdxW'(1);
        fsm_d = S_RD;
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      idx_q       <= '0;
      tick_q      <= '0;
      next_due_q  <= mtt_pkg::NO_DEADLINE;
      res_cnt_q   <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_st_q[i] <= mtt_pkg::ST_FREE;
      end
    end else begin
      fsm_q       <= fsm_d;
      idx_q       <= idx_d;
      tick_q      <= tick_d;
      next_due_q  <= next_due_d;
      res_cnt_q   <= res_cnt_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
      slot_st_q   <= slot_st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign in_i.ready  = fsm_q == S_IDLE;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // A held expiry result never survives the end of a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == S_IDLE) |-> !pend_v_q)
    else $error("held expiry result outside a scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= ResW'(mtt_pkg::RESULT_LIMIT))
    else $error("expiry count above the per-tick limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && item.op == mtt_pkg::OP_ARM && idx_ok) |=> (next_due_q <= $past(arm_due)))
    else $error("earliest deadline not lowered by arm");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && item.op == mtt_pkg::OP_TICK && (next_due_q > tick_inc))
      |=> (fsm_q == S_IDLE && next_due_q == $past(next_due_q)))
    else $error("tick before the deadline started a scan");

endmodule

// ===== sim/multi_timer_table_checker.sv =====
// Checker for the multi timer table: watches both channels, keeps its own copy of
// the slot table and deadline state, and compares every result transaction.
// Depends on mtt_pkg and the channel interfaces in mtt_intf.
`timescale 1ns / 1ps

module multi_timer_table_checker #(
  parameter int NUM_SLOTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  mtt_in_if    op_ch_i,
  mtt_out_if   res_ch_i,
  output int   errors_o,
  output int   pending_o,
  output int   ops_o,
  output int   results_o,
  output int   expired_o,
  output int   full_o
);

  logic [31:0] now_ticks;
  logic [31:0] earliest_due;
  logic [1:0]  slot_mode     [NUM_SLOTS];
  logic [31:0] slot_deadline [NUM_SLOTS];
  logic [7:0]  slot_tag_q    [NUM_SLOTS];
  logic [2:0]  slot_dest     [NUM_SLOTS];

  mtt_pkg::out_item_t awaited_results [$];

  int mismatches    = 0;
  int op_total      = 0;
  int result_total  = 0;
  int expired_total = 0;
  int full_total    = 0;

  // Applies one operation to the table copy and queues the results it causes.
  function automatic void predict_op(input mtt_pkg::in_item_t op_item);
    mtt_pkg::out_item_t   res;
    logic [31:0]          due;
    logic [NUM_SLOTS-1:0] hit;
    int                   fired;
    int                   final_hit;
    res       = '0;
    hit       = '0;
    fired     = 0;
    final_hit = 0;
    if (op_item.op <= mtt_pkg::OP_TICK) op_total++;
    case (op_item.op)
      mtt_pkg::OP_ALLOC: begin
        res.kind = mtt_pkg::KIND_FULL;
        res.last = 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_mode[i] == mtt_pkg::ST_FREE && res.kind == mtt_pkg::KIND_FULL) begin
            slot_mode[i] = mtt_pkg::ST_ALLOC;
            res.kind     = mtt_pkg::KIND_ALLOC;
            res.slot     = 4'(i);
          end
        end
        awaited_results.push_back(res);
      end
      mtt_pkg::OP_FREE: begin
        if (op_item.timer_index < NUM_SLOTS) begin
          slot_mode[op_item.timer_index] = mtt_pkg::ST_FREE;
        end
      end
      mtt_pkg::OP_BIND: begin
        if (op_item.timer_index < NUM_SLOTS) begin
          slot_tag_q[op_item.timer_index] = op_item.tag;
          slot_dest[op_item.timer_index]  = op_item.dest_queue;
        end
      end
      mtt_pkg::OP_ARM: begin
        if (op_item.timer_index < NUM_SLOTS) begin
          due = now_ticks + op_item.delay_ticks;
          slot_deadline[op_item.timer_index] = due;
          slot_mode[op_item.timer_index]     = mtt_pkg::ST_ARMED;
          if (earliest_due > due) earliest_due = due;
        end
      end
      mtt_pkg::OP_TICK: begin
        now_ticks = now_ticks + 32'd1;
        if (earliest_due <= now_ticks) begin
          // The earliest deadline is rebuilt only from slots that stay armed.
          earliest_due = mtt_pkg::NO_DEADLINE;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_mode[i] == mtt_pkg::ST_ARMED) begin
              if (slot_deadline[i] <= now_ticks && fired < mtt_pkg::RESULT_LIMIT) begin
                hit[i]       = 1'b1;
                final_hit    = i;
                fired++;
                slot_mode[i] = mtt_pkg::ST_ALLOC;
              end else if (earliest_due > slot_deadline[i]) begin
                earliest_due = slot_deadline[i];
              end
            end
          end
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (hit[i]) begin
              res.kind      = mtt_pkg::KIND_EXPIRED;
              res.slot      = 4'(i);
              res.tag_out   = slot_tag_q[i];
              res.queue_out = slot_dest[i];
              res.last      = (i == final_hit);
              awaited_results.push_back(res);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result(input mtt_pkg::out_item_t got);
    mtt_pkg::out_item_t want;
    result_total++;
    if (awaited_results.size() == 0) begin
      $error("Result transaction with nothing expected: kind %0d, slot %0d",
             got.kind, got.slot);
      mismatches++;
      return;
    end
    want = awaited_results.pop_front();
    if (want.kind == mtt_pkg::KIND_EXPIRED) expired_total++;
    if (want.kind == mtt_pkg::KIND_FULL) full_total++;
    compare_field("kind", 8'(want.kind), 8'(got.kind));
    compare_field("slot", 8'(want.slot), 8'(got.slot));
    compare_field("tag_out", want.tag_out, got.tag_out);
    compare_field("queue_out", 8'(want.queue_out), 8'(got.queue_out));
    compare_field("last", 8'(want.last), 8'(got.last));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_ticks    = '0;
      earliest_due = mtt_pkg::NO_DEADLINE;
      for (int i = 0; i < NUM_SLOTS; i++) slot_mode[i] = mtt_pkg::ST_FREE;
      awaited_results.delete();
    end else begin
      // A result can never stem from an operation accepted at the same edge.
      if (res_ch_i.valid && res_ch_i.ready) check_result(res_ch_i.data);
      if (op_ch_i.valid && op_ch_i.ready) predict_op(op_ch_i.data);
    end
    errors_o  <= mismatches;
    pending_o <= awaited_results.size();
    ops_o     <= op_total;
    results_o <= result_total;
    expired_o <= expired_total;
    full_o    <= full_total;
  end

endmodule

// ===== sim/multi_timer_table_test.sv =====
// Top of the multi timer table testbench: clock, reset, operation stimulus and
// result-side stalls. Needs mtt_pkg, mtt_intf, the block and multi_timer_table_checker.
`timescale 1ns / 1ps

module multi_timer_table_test;

  localparam int NUM_SLOTS  = 16;
  localparam int ITEM_COUNT = 460;
  localparam int OP_CODES   = 8;
  localparam int LONG_HOLD  = 300;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE     = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mtt_in_if  in_ch ();
  mtt_out_if out_ch ();

  int items_sent    = 0;
  int hold_requests = 0;
  bit calm          = 1'b0;
  bit bound [NUM_SLOTS];

  int chk_errors;
  int chk_pending;
  int chk_ops;
  int chk_results;
  int chk_expired;
  int chk_full;

  always #5 clk_i = ~clk_i;

  multi_timer_table #(
    .NUM_SLOTS(NUM_SLOTS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  multi_timer_table_checker #(
    .NUM_SLOTS(NUM_SLOTS)
  ) table_chk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_ch_i  (in_ch),
    .res_ch_i (out_ch),
    .errors_o (chk_errors),
    .pending_o(chk_pending),
    .ops_o    (chk_ops),
    .results_o(chk_results),
    .expired_o(chk_expired),
    .full_o   (chk_full)
  );

  // Mostly back to back, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic mtt_pkg::in_item_t rand_item();
    mtt_pkg::in_item_t item;
    item.op          = 3'($urandom);
    item.timer_index = 4'($urandom);
    item.delay_ticks = $urandom;
    item.tag         = 8'($urandom);
    item.dest_queue  = 3'($urandom);
    return item;
  endfunction

  task automatic send_op(input mtt_pkg::in_item_t item);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk_i); while (!in_ch.ready);
    if (item.op <= mtt_pkg::OP_TICK) items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic simple_op(input logic [2:0] op, input int idx);
    mtt_pkg::in_item_t item;
    item             = rand_item();
    item.op          = op;
    item.timer_index = 4'(idx);
    send_op(item);
  endtask

  task automatic bind_slot(input int idx, input logic [7:0] tag, input logic [2:0] dest);
    mtt_pkg::in_item_t item;
    item             = rand_item();
    item.op          = mtt_pkg::OP_BIND;
    item.timer_index = 4'(idx);
    item.tag         = tag;
    item.dest_queue  = dest;
    bound[idx]       = 1'b1;
    send_op(item);
  endtask

  // A slot is always bound before its first arm, so no expiry reports an unwritten tag.
  task automatic arm_slot(input int idx, input logic [31:0] delay);
    mtt_pkg::in_item_t item;
    if (!bound[idx]) bind_slot(idx, 8'($urandom), 3'($urandom));
    item             = rand_item();
    item.op          = mtt_pkg::OP_ARM;
    item.timer_index = 4'(idx);
    item.delay_ticks = delay;
    send_op(item);
  endtask

  initial begin
    int holds_served;
    holds_served = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_requests != holds_served) begin
        holds_served++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (calm || $urandom_range(0, 99) < 55) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int r;
    int idx;
    bit pressure_done;
    pressure_done = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: wrap of a deadline, stale deadline after a free,
    // arming a free slot, a far deadline, unknown codes.
    simple_op(mtt_pkg::OP_ALLOC, 0);
    simple_op(mtt_pkg::OP_ALLOC, NUM_SLOTS - 1);
    simple_op(mtt_pkg::OP_TICK, 0);
    bind_slot(0, 8'hFF, 3'd7);
    bind_slot(NUM_SLOTS - 1, 8'h00, 3'd0);
    arm_slot(0, 32'd0);
    arm_slot(NUM_SLOTS - 1, mtt_pkg::NO_DEADLINE);
    simple_op(mtt_pkg::OP_TICK, 0);
    arm_slot(1, 32'd1);
    simple_op(mtt_pkg::OP_FREE, 1);
    simple_op(mtt_pkg::OP_TICK, 0);
    arm_slot(2, 32'd1);
    simple_op(mtt_pkg::OP_TICK, 0);
    arm_slot(3, 32'hFFFF_FFF0);
    simple_op(mtt_pkg::OP_TICK, 0);
    for (int u = int'(mtt_pkg::OP_TICK) + 1; u < OP_CODES; u++) simple_op(3'(u), u);
    simple_op(mtt_pkg::OP_ALLOC, 0);

    while (items_sent < ITEM_COUNT) begin
      calm = (items_sent >= 120 && items_sent < 170);
      if (!pressure_done && items_sent >= 220) begin
        // Results back up behind a stalled receiver until the input stalls too.
        pressure_done = 1'b1;
        hold_requests <= hold_requests + 1;
        repeat (NUM_SLOTS + 4) simple_op(mtt_pkg::OP_ALLOC, $urandom_range(0, NUM_SLOTS - 1));
        for (int i = 0; i < NUM_SLOTS; i++) simple_op(mtt_pkg::OP_FREE, i);
      end
      r   = $urandom_range(0, 99);
      idx = $urandom_range(0, NUM_SLOTS - 1);
      if (r < 35) begin
        simple_op(mtt_pkg::OP_ALLOC, idx);
        bind_slot(idx, 8'($urandom), 3'($urandom));
        arm_slot(idx, $urandom_range(0, 6));
        repeat ($urandom_range(1, 4)) begin
          simple_op(mtt_pkg::OP_TICK, $urandom_range(0, NUM_SLOTS - 1));
        end
      end else if (r < 58) begin
        repeat ($urandom_range(1, 6)) begin
          simple_op(mtt_pkg::OP_TICK, $urandom_range(0, NUM_SLOTS - 1));
        end
      end else if (r < 74) begin
        arm_slot(idx, ($urandom_range(0, 9) < 7) ? $urandom_range(0, 20) : $urandom);
      end else if (r < 84) begin
        simple_op(mtt_pkg::OP_FREE, idx);
      end else if (r < 92) begin
        bind_slot(idx, 8'($urandom), 3'($urandom));
      end else if (r < 96) begin
        simple_op(mtt_pkg::OP_ALLOC, idx);
      end else begin
        simple_op(3'($urandom_range(int'(mtt_pkg::OP_TICK) + 1, OP_CODES - 1)), idx);
      end
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    // The checker's pending count is registered, so it reflects the final transaction only after the next edge.
    @(posedge clk_i);
    while (chk_pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("Ran %0d table operations through the block; %0d results came back.",
             chk_ops, chk_results);
    $display("Among them %0d slot expirations and %0d no-free-slot answers.",
             chk_expired, chk_full);
    if (chk_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
